// ===== rtl/assert_macros.svh =====
// Assertion shorthands shared by the interpolator RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed");

// Implication after a fixed number of cycles
`define ASSERT_DELAY(lbl, clk, rst_n, a, n, c) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> ##(n) (c)) \
		else $error("assertion failed");

`endif

// ===== rtl/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; imported by pli_div_stage and the top level.
package pli_pkg;

	localparam int POS_W      = 8;
	localparam int VAL_W      = 16;
	localparam int CNT_W      = 3;
	localparam int WORD_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int REG_POINTS = 4;
	localparam int PROD_W     = POS_W + VAL_W;

	// quotient bits resolved per divider stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = VAL_W / DIV_STEPS;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_WORD_0 = 3'd1;

	// state of one item inside the divider
	typedef struct packed {
		logic [POS_W-1:0] rem;   // partial remainder, always below span
		logic [VAL_W-1:0] low;   // dividend bits not yet shifted in
		logic [VAL_W-1:0] quot;  // quotient bits so far
		logic [POS_W-1:0] span;  // divisor
		logic             neg;   // slope is negative
		logic [VAL_W-1:0] base;  // lower breakpoint value
	} div_t;

endpackage

// ===== rtl/piecewise_linear_interpolator_top.sv =====
// Piecewise linear interpolator, top level: config registers, segment select,
// multiply and output stages. Depends on pli_pkg, pli_div_stage, assert_macros.svh.
// Usage: busy is always low, so an item is taken on every cycle start is high; the
// value for that item appears on value_out with done high for one cycle, after the
// stage 1 and 2 registers, the DIV_STAGES divider stages and the output register;
// one result per item, in order. Stage one picks the segment, stage two multiplies;
// a pipelined restoring divider resolves the 16-bit quotient four bits per stage.
// done cannot be held off. cfg_ready is always high; write registers only while no
// item is in flight. Index 0 is the breakpoint count, 1..4 the breakpoint words;
// other indexes are ignored.
`include "assert_macros.svh"

module piecewise_linear_interpolator_top #(
	parameter int MAX_POINTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [pli_pkg::POS_W-1:0]       position,
	output logic                            done,
	output logic [pli_pkg::VAL_W-1:0]       value_out,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pli_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pli_pkg::WORD_W-1:0]      cfg_data
);
	import pli_pkg::*;

	localparam int NUM_WORDS = (MAX_POINTS < REG_POINTS) ? MAX_POINTS : REG_POINTS;
	localparam int LATENCY   = DIV_STAGES + 3;

	function automatic logic [POS_W-1:0] word_pos(input logic [WORD_W-1:0] w);
		return w[WORD_W-1:VAL_W];
	endfunction

	function automatic logic [VAL_W-1:0] word_val(input logic [WORD_W-1:0] w);
		return w[VAL_W-1:0];
	endfunction

	logic [CNT_W-1:0]  count_q;
	logic [WORD_W-1:0] word_q [NUM_WORDS];
	logic [CNT_W-1:0]  n_eff;
	logic              accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				word_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_POINT_COUNT) begin
				count_q <= cfg_data[CNT_W-1:0];
			end
			for (int i = 0; i < NUM_WORDS; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_POINT_WORD_0 + i)) begin
					word_q[i] <= cfg_data;
				end
			end
		end
	end

	// count saturated to the breakpoints held
	assign n_eff = (count_q > CNT_W'(NUM_WORDS)) ? CNT_W'(NUM_WORDS) : count_q;

	// segment select: base value, slope magnitude and sign, distance, span
	logic [VAL_W-1:0] base_c;
	logic [VAL_W-1:0] mag_c;
	logic             neg_c;
	logic [POS_W-1:0] dist_c;
	logic [POS_W-1:0] span_c;

	always_comb begin
		logic              hit;
		logic [WORD_W-1:0] hi_w;
		logic [WORD_W-1:0] lo_w;
		logic [VAL_W-1:0]  last_val;
		hit      = 1'b0;
		hi_w     = '0;
		lo_w     = '0;
		last_val = '0;
		base_c   = '0;
		mag_c    = '0;
		neg_c    = 1'b0;
		dist_c   = '0;
		span_c   = POS_W'(1);
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (CNT_W'(i + 1) == n_eff) begin
				last_val = word_val(word_q[i]);
			end
		end
		// descending, so the lowest matching breakpoint wins
		for (int i = NUM_WORDS - 1; i >= 1; i--) begin
			if (CNT_W'(i) < n_eff && position <= word_pos(word_q[i])) begin
				hit  = 1'b1;
				hi_w = word_q[i];
				lo_w = word_q[i-1];
			end
		end
		if (n_eff != '0) begin
			if (position <= word_pos(word_q[0])) begin
				base_c = word_val(word_q[0]);
			end else if (hit) begin
				if (word_pos(hi_w) <= word_pos(lo_w)) begin
					base_c = word_val(hi_w);
				end else begin
					base_c = word_val(lo_w);
					span_c = word_pos(hi_w) - word_pos(lo_w);
					dist_c = position - word_pos(lo_w);
					neg_c  = word_val(hi_w) < word_val(lo_w);
					mag_c  = neg_c ? word_val(lo_w) - word_val(hi_w)
					               : word_val(hi_w) - word_val(lo_w);
				end
			end else begin
				base_c = last_val;
			end
		end
	end

	// stage 1 registers
	logic             valid_s1;
	logic [VAL_W-1:0] base_s1;
	logic [VAL_W-1:0] mag_s1;
	logic             neg_s1;
	logic [POS_W-1:0] dist_s1;
	logic [POS_W-1:0] span_s1;

	// stage 2 registers
	logic              valid_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [VAL_W-1:0]  base_s2;
	logic              neg_s2;
	logic [POS_W-1:0]  span_s2;

	// output stage
	logic             done_s7;
	logic [VAL_W-1:0] value_s7;

	logic dv_valid [DIV_STAGES+1];
	div_t dv       [DIV_STAGES+1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_s7  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done_s7  <= dv_valid[DIV_STAGES];
		end
	end

	// payload: segment, product, final add
	always_ff @(posedge clk) begin
		base_s1  <= base_c;
		mag_s1   <= mag_c;
		neg_s1   <= neg_c;
		dist_s1  <= dist_c;
		span_s1  <= span_c;
		prod_s2  <= PROD_W'(mag_s1) * PROD_W'(dist_s1);
		base_s2  <= base_s1;
		neg_s2   <= neg_s1;
		span_s2  <= span_s1;
		value_s7 <= dv[DIV_STAGES].neg ? dv[DIV_STAGES].base - dv[DIV_STAGES].quot
		                               : dv[DIV_STAGES].base + dv[DIV_STAGES].quot;
	end

	// divider input; quotient fits 16 bits since distance never exceeds span
	assign dv_valid[0] = valid_s2;
	always_comb begin
		dv[0].rem  = prod_s2[PROD_W-1:VAL_W];
		dv[0].low  = prod_s2[VAL_W-1:0];
		dv[0].quot = '0;
		dv[0].span = span_s2;
		dv[0].neg  = neg_s2;
		dv[0].base = base_s2;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		pli_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[g]),
			.in_data   (dv[g]),
			.out_valid (dv_valid[g+1]),
			.out_data  (dv[g+1])
		);
	end

	assign done      = done_s7;
	assign value_out = value_s7;

	`ASSERT_DELAY(a_latency, clk, arst_n, accept, LATENCY, done)
	`ASSERT_IMPLY(a_done_has_item, clk, arst_n, done, $past(accept, LATENCY))
	`ASSERT_IMPLY(a_span_nonzero, clk, arst_n, valid_s1, span_s1 != '0)

endmodule

// ===== rtl/pli_div_stage.sv =====
// One register stage of the restoring divider: DIV_STEPS quotient bits.
// Depends on pli_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pli_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  pli_pkg::div_t in_data,
	output logic          out_valid,
	output pli_pkg::div_t out_data
);
	import pli_pkg::*;

	logic valid_s;
	div_t work_s;
	div_t nxt;

	// shift-subtract steps
	always_comb begin
		logic [POS_W:0] trial;
		logic           qbit;
		nxt = in_data;
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial = {nxt.rem, nxt.low[VAL_W-1]};
			if (trial >= {1'b0, nxt.span}) begin
				trial = trial - {1'b0, nxt.span};
				qbit  = 1'b1;
			end else begin
				qbit  = 1'b0;
			end
			nxt.rem  = trial[POS_W-1:0];
			nxt.quot = {nxt.quot[VAL_W-2:0], qbit};
			nxt.low  = {nxt.low[VAL_W-2:0], 1'b0};
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		work_s <= nxt;
	end

	assign out_valid = valid_s;
	assign out_data  = work_s;

	`ASSERT_IMPLY(a_rem_below_span, clk, arst_n, valid_s, work_s.rem < work_s.span)

endmodule

// ===== verif/piecewise_linear_interpolator_top_test.sv =====
// Self-checking testbench for piecewise_linear_interpolator_top: directed table, then
// randomized breakpoint settings and query positions, each checked by an interpolation predictor.
// Depends on pli_pkg and the interpolator RTL.
module piecewise_linear_interpolator_top_test;
	import pli_pkg::*;

	localparam int MAX_PTS     = 4;
	localparam int LATENCY     = DIV_STAGES + 3;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 480;
	localparam int N_DIR       = 40;
	localparam int PT_IDX_W    = $clog2(REG_POINTS);

	// breakpoint word indexes, then the unused indexes above them
	localparam logic [CFG_IDX_W-1:0] REG_WORD_1   = REG_POINT_WORD_0 + 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_2   = REG_POINT_WORD_0 + 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_3   = REG_POINT_WORD_0 + 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_POINT_WORD_0 + CFG_IDX_W'(REG_POINTS);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// one directed row: a register write, or a query with an optional typed-in value
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [WORD_W-1:0]     data;
		logic                  typed;
		logic [VAL_W-1:0]      want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [POS_W-1:0]      position;
	logic                  done;
	logic [VAL_W-1:0]      value_out;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [WORD_W-1:0]     cfg_data;

	// predictor copy of the breakpoint registers
	logic [CNT_W-1:0]      pt_count;
	logic [WORD_W-1:0]     pt_word [REG_POINTS];

	logic [VAL_W-1:0]      expected_values [$];
	logic [VAL_W-1:0]      oldest_value;
	int                    mismatch_count = 0;
	int                    stall_cycles = 0;
	bit                    idle_on = 1'b1;

	dir_row_t directed_rows [N_DIR] = '{
		// after reset: no breakpoints, output is zero
		'{ROW_ITEM, REG_POINT_COUNT, 24'd0,       1'b1, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'h0000},
		// four sorted breakpoints, rising then falling then rising
		'{ROW_CFG,  REG_POINT_COUNT, 24'd4,       1'b0, 16'h0000},
		'{ROW_CFG,  REG_POINT_WORD_0, 24'h10_0100, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_1,      24'h40_0400, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_2,      24'h80_0200, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_3,      24'hFF_FFFF, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd0,       1'b1, 16'h0100},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd16,      1'b1, 16'h0100},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd40,      1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd64,      1'b1, 16'h0400},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd100,     1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd200,     1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'hFFFF},
		// count too large saturates to four
		'{ROW_CFG,  REG_POINT_COUNT, 24'd7,       1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'hFFFF},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd130,     1'b0, 16'h0000},
		// above the last breakpoint holds its value
		'{ROW_CFG,  REG_WORD_3,      24'hC8_8000, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'h8000},
		// writes to unused indexes change nothing
		'{ROW_CFG,  REG_SPARE_LO,    24'hFF_FFFF, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_SPARE_HI,    24'hFF_FFFF, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'h8000},
		// single breakpoint: constant output
		'{ROW_CFG,  REG_POINT_COUNT, 24'd1,       1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd0,       1'b1, 16'h0100},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'h0100},
		// unsorted breakpoints
		'{ROW_CFG,  REG_POINT_COUNT, 24'd3,       1'b0, 16'h0000},
		'{ROW_CFG,  REG_POINT_WORD_0, 24'h32_1111, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_1,      24'h0A_2222, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd100,     1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd30,      1'b0, 16'h0000},
		// full-range segment, rising then falling
		'{ROW_CFG,  REG_POINT_COUNT, 24'd2,       1'b0, 16'h0000},
		'{ROW_CFG,  REG_POINT_WORD_0, 24'h00_0000, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_1,      24'hFF_FFFF, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd128,     1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd0,       1'b1, 16'h0000},
		'{ROW_CFG,  REG_POINT_WORD_0, 24'h00_FFFF, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_WORD_1,      24'hFF_0000, 1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd1,       1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd254,     1'b0, 16'h0000},
		'{ROW_ITEM, REG_POINT_COUNT, 24'd255,     1'b1, 16'h0000}
	};

	piecewise_linear_interpolator_top #(
		.MAX_POINTS(MAX_PTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.position(position),
		.done(done),
		.value_out(value_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// expected value for one query under the current breakpoints
	function automatic logic [VAL_W-1:0] interp_value(input logic [POS_W-1:0] p);
		int n, i, lo_pos, hi_pos, lo_val, hi_val, span, r;
		logic [VAL_W-1:0] res;
		logic found;
		n = pt_count;
		if (n > MAX_PTS) n = MAX_PTS;
		if (n > REG_POINTS) n = REG_POINTS;
		if (n == 0) return '0;
		if (p <= pt_word[0][VAL_W +: POS_W]) return pt_word[0][VAL_W-1:0];
		found = 1'b0;
		res = pt_word[n-1][VAL_W-1:0];
		for (i = 1; i < n; i++) begin
			if (!found && p <= pt_word[i][VAL_W +: POS_W]) begin
				found  = 1'b1;
				lo_pos = pt_word[i-1][VAL_W +: POS_W];
				hi_pos = pt_word[i][VAL_W +: POS_W];
				lo_val = pt_word[i-1][VAL_W-1:0];
				hi_val = pt_word[i][VAL_W-1:0];
				span   = hi_pos - lo_pos;
				if (span <= 0) begin
					res = hi_val[VAL_W-1:0];
				end else begin
					// signed quotient truncates toward zero
					r = lo_val + ((int'(p) - lo_pos) * (hi_val - lo_val)) / span;
					if (r < 0) r = 0;
					if (r > 65535) r = 65535;
					res = r[VAL_W-1:0];
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// one query item; start stays high for a following item
	task automatic send_position(input logic [POS_W-1:0] p, input logic typed,
			input logic [VAL_W-1:0] want);
		while (idle_on && $urandom_range(99) < 11) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		position <= p;
		do @(posedge clk); while (busy);
		expected_values.push_back(typed ? want : interp_value(p));
	endtask

	// one register write; cfg_valid is left high for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		while (idle_on && $urandom_range(99) < 11) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_POINT_COUNT) begin
			pt_count = data[CNT_W-1:0];
		end else if (idx < REG_SPARE_LO) begin
			pt_word[PT_IDX_W'(idx - REG_POINT_WORD_0)] = data;
		end
	endtask

	// stop sending and wait until every result is back
	task automatic drain_results();
		start <= 1'b0;
		while (expected_values.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_values.size() == 0) begin
				report_mismatch($sformatf("unexpected result value_out=%h", value_out));
			end else begin
				oldest_value = expected_values.pop_front();
				if (value_out !== oldest_value)
					report_mismatch($sformatf("value_out=%h expected %h",
						value_out, oldest_value));
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int row, k, sent, phase, pacc, tmp, n_items;
		row_kind_t last_kind;
		logic [WORD_W-1:0] word;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		position  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POINT_COUNT;
		cfg_data  <= '0;
		pt_count  = '0;
		for (k = 0; k < REG_POINTS; k++) pt_word[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		last_kind = ROW_ITEM;
		for (row = 0; row < N_DIR; row++) begin
			if (directed_rows[row].kind == ROW_CFG) begin
				if (last_kind == ROW_ITEM) drain_results();
				write_reg(directed_rows[row].idx, directed_rows[row].data);
			end else begin
				if (last_kind == ROW_CFG) cfg_valid <= 1'b0;
				send_position(directed_rows[row].data[POS_W-1:0], directed_rows[row].typed,
					directed_rows[row].want);
			end
			last_kind = directed_rows[row].kind;
		end
		drain_results();

		// random phases: new breakpoints, then a burst of queries
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			idle_on = (phase != 2);
			tmp = $urandom_range(9);
			write_reg(REG_POINT_COUNT, (tmp > 7) ? WORD_W'(MAX_PTS) : WORD_W'(tmp));
			tmp  = $urandom_range(9);
			pacc = $urandom_range(60);
			for (k = 0; k < REG_POINTS; k++) begin
				if (tmp == 0) begin
					// arbitrary words, usually unsorted
					word = WORD_W'($urandom());
				end else if (tmp == 1) begin
					// extremes of position and value
					word = {($urandom_range(1) ? 8'hFF : 8'h00),
						($urandom_range(1) ? 16'hFFFF : 16'h0000)};
				end else begin
					// nondecreasing positions, repeats allowed
					word = {pacc[POS_W-1:0], 16'($urandom())};
					pacc = pacc + $urandom_range(90);
					if (pacc > 255) pacc = 255;
				end
				write_reg(REG_POINT_WORD_0 + CFG_IDX_W'(k), word);
			end
			if ($urandom_range(3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
					WORD_W'($urandom()));
			cfg_valid <= 1'b0;

			n_items = $urandom_range(70, 30);
			for (k = 0; k < n_items; k++) begin
				if ($urandom_range(3) == 0) begin
					// land on or next to a breakpoint
					tmp = int'(pt_word[PT_IDX_W'($urandom_range(REG_POINTS-1))][VAL_W +: POS_W])
						+ $urandom_range(2) - 1;
					send_position(tmp[POS_W-1:0], 1'b0, '0);
				end else begin
					send_position(POS_W'($urandom()), 1'b0, '0);
				end
			end
			sent += n_items;
			phase++;
			drain_results();
		end

		// let any stray result show up before the verdict
		repeat (LATENCY + 2) @(posedge clk);
		if (expected_values.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_values.size()));
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
